### src/tcg_pkg.sv
// tcg_pkg: shared types, constants and the reset palette of the text cell glyph renderer
// no dependencies; imported by every module of the block

package tcg_pkg;

   // grid and font geometry
   localparam int GRID_COLUMNS = 40;
   localparam int GRID_ROWS    = 16;
   localparam int CURSOR_LINES = 2;
   localparam int GLYPH_COUNT  = 256;

   localparam int CELL_H     = 8;
   localparam int FONT_COLS  = 5;
   localparam int FONT_BYTES = GLYPH_COUNT * FONT_COLS;
   localparam int GLYPH_AW   = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int PAL_DEPTH  = 16;

   // item modes
   localparam logic [1:0] MODE_RENDER  = 2'd0;
   localparam logic [1:0] MODE_FONT_WR = 2'd1;
   localparam logic [1:0] MODE_PAL_WR  = 2'd2;

   // register index, taken from paddr[2]
   localparam logic REG_TOP_OFFSET = 1'b0;

   // reciprocal of five, scaled by 2^16, for font address split
   localparam logic [13:0] RECIP5 = 14'd13108;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  char_code;
      logic [3:0]  fg_index;
      logic [3:0]  bg_index;
      logic        cursor_on;
      logic [5:0]  cell_col;
      logic [4:0]  text_row;
      logic [10:0] table_index;
      logic [15:0] table_value;
   } req_type;

   typedef struct packed {
      logic [8:0]  pixel_x;
      logic [8:0]  pixel_y;
      logic [2:0]  glyph_line;
      logic [15:0] pix0;
      logic [15:0] pix1;
      logic [15:0] pix2;
      logic [15:0] pix3;
      logic [15:0] pix4;
      logic [15:0] pix5;
      logic        last_line;
   } rsp_type;

   // one glyph: five font columns, bit n of a column is glyph row n
   typedef logic [FONT_COLS-1:0][7:0] glyph_type;

   typedef struct packed {
      logic                en;
      logic [GLYPH_AW-1:0] row;
      logic [2:0]          lane;
      logic [7:0]          data;
   } font_wr_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  idx;
      logic [15:0] data;
   } pal_wr_type;

   typedef struct packed {
      glyph_type   glyph;
      logic [15:0] fg;
      logic [15:0] bg;
      logic        cursor;
      logic [5:0]  col;
      logic [4:0]  row;
   } line_load_type;

   typedef struct packed {
      logic active;
      logic last;
   } line_status_type;

   // sixteen reset colors in RGB565
   function automatic logic [15:0] cga_color(input logic [3:0] idx);
      logic [15:0] c;
      unique case (idx)
         4'd0:  c = 16'h0000;
         4'd1:  c = 16'h0015;
         4'd2:  c = 16'h0540;
         4'd3:  c = 16'h0555;
         4'd4:  c = 16'hA800;
         4'd5:  c = 16'hA815;
         4'd6:  c = 16'hA520;
         4'd7:  c = 16'hAD55;
         4'd8:  c = 16'h52AA;
         4'd9:  c = 16'h52BF;
         4'd10: c = 16'h57EA;
         4'd11: c = 16'h57FF;
         4'd12: c = 16'hFAAA;
         4'd13: c = 16'hFABF;
         4'd14: c = 16'hFFE0;
         4'd15: c = 16'hFFFF;
         default: c = 16'h0000;
      endcase
      return c;
   endfunction

endpackage

### src/text_cell_glyph_renderer_unit.sv
// text_cell_glyph_renderer_unit: top level, command port, register port and read stage
// depends on tcg_pkg, tcg_font_mem, tcg_palette, tcg_line_gen

// A render command for a cell inside the grid gives eight result beats on consecutive
// cycles, glyph rows 0 to 7. When the block is idle, row 0 passes the read stage, the
// row sequencer and the output register before it is on the result ports.
// The row sequencer emits one glyph row per cycle, so back-to-back cells are taken only
// as fast as their rows are emitted; one command waits in the read stage while the
// previous cell is still being emitted. Font and palette writes, and cells outside the
// grid, are taken whenever busy is low and give no beat. Results come out on rsp_valid
// for exactly one cycle and cannot be held off. The palette starts at the sixteen reset
// colors with no clearing pass; the font store holds nothing defined until it is written.

module text_cell_glyph_renderer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcg_pkg::req_type req_data,
   output logic             rsp_valid,
   output tcg_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import tcg_pkg::*;

   logic            accept;
   logic            in_grid;
   logic            render_go;
   logic            csr_wr;
   logic [7:0]      top_offset_ff;
   logic [7:0]      top_offset_in;
   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic            s1_blank_ff;
   logic            s1_cursor_ff;
   logic [5:0]      s1_col_ff;
   logic [4:0]      s1_row_ff;
   logic            eng_load;
   line_status_type eng_status;
   line_load_type   eng_data;
   font_wr_type     font_wr;
   pal_wr_type      pal_wr;
   glyph_type       font_rdata;
   logic [15:0]     fg_color;
   logic [15:0]     bg_color;
   logic [24:0]     quot_full;
   logic [8:0]      quot;
   logic [10:0]     lane_full;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TOP_OFFSET);
   assign top_offset_in = csr_wr ? pwdata[7:0] : top_offset_ff;
   assign prdata = (paddr[2] == REG_TOP_OFFSET) ? {24'd0, top_offset_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_offset_ff <= 8'd3;
      end else begin
         top_offset_ff <= top_offset_in;
      end
   end

   // command decode
   assign accept    = start && !busy;
   assign in_grid   = (7'(req_data.cell_col) < 7'(GRID_COLUMNS))
                   && (6'(req_data.text_row) < 6'(GRID_ROWS));
   assign render_go = accept && (req_data.mode == MODE_RENDER) && in_grid;

   // font address split into glyph row and column lane
   assign quot_full = 25'(req_data.table_index) * 25'(RECIP5);
   assign quot      = quot_full[24:16];
   assign lane_full = req_data.table_index - 11'(11'(quot) * 11'd5);

   always_comb begin
      font_wr.en   = accept && (req_data.mode == MODE_FONT_WR)
                  && (req_data.table_index < 11'(FONT_BYTES));
      font_wr.row  = quot[GLYPH_AW-1:0];
      font_wr.lane = lane_full[2:0];
      font_wr.data = req_data.table_value[7:0];
      pal_wr.en    = accept && (req_data.mode == MODE_PAL_WR)
                  && (req_data.table_index < 11'(PAL_DEPTH));
      pal_wr.idx   = req_data.table_index[3:0];
      pal_wr.data  = req_data.table_value;
   end

   // read stage handoff to the row sequencer
   assign eng_load = s1_valid_ff && (!eng_status.active || eng_status.last);
   assign busy     = s1_valid_ff && !eng_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      priority if (render_go) begin
         s1_valid_in = 1'b1;
      end else if (eng_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (render_go) begin
         s1_blank_ff  <= ({1'b0, req_data.char_code} >= 9'(GLYPH_COUNT));
         s1_cursor_ff <= req_data.cursor_on;
         s1_col_ff    <= req_data.cell_col;
         s1_row_ff    <= req_data.text_row;
      end
   end

   always_comb begin
      eng_data.glyph  = s1_blank_ff ? '0 : font_rdata;
      eng_data.fg     = fg_color;
      eng_data.bg     = bg_color;
      eng_data.cursor = s1_cursor_ff;
      eng_data.col    = s1_col_ff;
      eng_data.row    = s1_row_ff;
   end

   tcg_font_mem u_font (
      .clock   (clock),
      .font_wr (font_wr),
      .rd_en   (render_go),
      .rd_row  (req_data.char_code[GLYPH_AW-1:0]),
      .rd_data (font_rdata)
   );

   tcg_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .pal_wr   (pal_wr),
      .rd_en    (render_go),
      .fg_idx   (req_data.fg_index),
      .bg_idx   (req_data.bg_index),
      .fg_color (fg_color),
      .bg_color (bg_color)
   );

   tcg_line_gen u_line_gen (
      .clock      (clock),
      .reset      (reset),
      .load       (eng_load),
      .load_data  (eng_data),
      .top_offset (top_offset_ff),
      .status     (eng_status),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // rows of one cell come out back to back in order
   a_rows_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.glyph_line != 3'(CELL_H - 1))
      |=> rsp_valid && (rsp_data.glyph_line == $past(rsp_data.glyph_line) + 3'd1))
      else $error("glyph rows of a cell not contiguous");

   // last mark only on the bottom glyph row
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_line == (rsp_data.glyph_line == 3'(CELL_H - 1))))
      else $error("last mark on wrong glyph row");

   // idle block has row 0 on the result ports after the read stage, row sequencer and output register
   a_idle_latency: assert property (@(posedge clock) disable iff (reset)
      render_go && !s1_valid_ff && !eng_status.active
      |-> ##3 (rsp_valid && (rsp_data.glyph_line == 3'd0)))
      else $error("first row of an idle cell late");

   // a waiting cell is never dropped
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !eng_load |=> s1_valid_ff)
      else $error("waiting cell lost");

endmodule

### src/tcg_font_mem.sv
// tcg_font_mem: font store, one glyph of five column bytes per row, byte-lane writes
// depends on tcg_pkg

module tcg_font_mem (
   input  logic                clock,
   input  tcg_pkg::font_wr_type font_wr,
   input  logic                rd_en,
   input  logic [tcg_pkg::GLYPH_AW-1:0] rd_row,
   output tcg_pkg::glyph_type  rd_data
);
   import tcg_pkg::*;

   glyph_type font_ram_ff [GLYPH_COUNT];
   glyph_type rd_data_ff;

   // single byte lane write
   always_ff @(posedge clock) begin
      if (font_wr.en) begin
         font_ram_ff[font_wr.row][font_wr.lane] <= font_wr.data;
      end
   end

   // registered whole-glyph read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= font_ram_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tcg_palette.sv
// tcg_palette: 16-entry color memory with two read ports and per-entry valid bits
// depends on tcg_pkg; unwritten entries read as the reset colors

module tcg_palette (
   input  logic                clock,
   input  logic                reset,
   input  tcg_pkg::pal_wr_type pal_wr,
   input  logic                rd_en,
   input  logic [3:0]          fg_idx,
   input  logic [3:0]          bg_idx,
   output logic [15:0]         fg_color,
   output logic [15:0]         bg_color
);
   import tcg_pkg::*;

   logic [15:0]          pal_ram_ff [PAL_DEPTH];
   logic [PAL_DEPTH-1:0] valid_ff;
   logic [PAL_DEPTH-1:0] valid_in;
   logic [15:0]          fg_data_ff;
   logic [15:0]          bg_data_ff;
   logic [3:0]           fg_idx_ff;
   logic [3:0]           bg_idx_ff;
   logic                 fg_valid_ff;
   logic                 bg_valid_ff;

   // valid bits
   always_comb begin
      valid_in = valid_ff;
      if (pal_wr.en) begin
         valid_in[pal_wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory write
   always_ff @(posedge clock) begin
      if (pal_wr.en) begin
         pal_ram_ff[pal_wr.idx] <= pal_wr.data;
      end
   end

   // two registered reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fg_data_ff  <= pal_ram_ff[fg_idx];
         bg_data_ff  <= pal_ram_ff[bg_idx];
         fg_idx_ff   <= fg_idx;
         bg_idx_ff   <= bg_idx;
         fg_valid_ff <= valid_ff[fg_idx];
         bg_valid_ff <= valid_ff[bg_idx];
      end
   end

   // unwritten entries fall back to the reset colors
   assign fg_color = fg_valid_ff ? fg_data_ff : cga_color(fg_idx_ff);
   assign bg_color = bg_valid_ff ? bg_data_ff : cga_color(bg_idx_ff);

endmodule

### src/tcg_line_gen.sv
// tcg_line_gen: glyph row sequencer, expands one loaded cell into eight result beats
// depends on tcg_pkg

module tcg_line_gen (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tcg_pkg::line_load_type   load_data,
   input  logic [7:0]               top_offset,
   output tcg_pkg::line_status_type status,
   output logic                     rsp_valid,
   output tcg_pkg::rsp_type         rsp_data
);
   import tcg_pkg::*;

   logic          active_ff;
   logic          active_in;
   logic [2:0]    line_ff;
   logic [2:0]    line_in;
   line_load_type cell_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          last;
   logic          under;
   logic [15:0]   pix [FONT_COLS];

   assign last = active_ff && (line_ff == 3'(CELL_H - 1));

   // sequencer control
   always_comb begin
      active_in = active_ff;
      line_in   = line_ff;
      if (load) begin
         active_in = 1'b1;
         line_in   = '0;
      end else if (active_ff) begin
         line_in = line_ff + 3'd1;
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         line_ff   <= '0;
      end else begin
         active_ff <= active_in;
         line_ff   <= line_in;
      end
   end

   // cell hold register
   always_ff @(posedge clock) begin
      if (load) begin
         cell_ff <= load_data;
      end
   end

   // pixel row for the current glyph line
   always_comb begin
      under = cell_ff.cursor && (4'(line_ff) >= 4'(CELL_H - CURSOR_LINES));
      for (int c = 0; c < FONT_COLS; c++) begin
         pix[c] = (under || cell_ff.glyph[c][line_ff]) ? cell_ff.fg : cell_ff.bg;
      end
      rsp_in.pixel_x    = 9'({cell_ff.col, 2'b00}) + 9'({cell_ff.col, 1'b0});
      rsp_in.pixel_y    = 9'(top_offset) + 9'({cell_ff.row, line_ff});
      rsp_in.glyph_line = line_ff;
      rsp_in.pix0       = pix[0];
      rsp_in.pix1       = pix[1];
      rsp_in.pix2       = pix[2];
      rsp_in.pix3       = pix[3];
      rsp_in.pix4       = pix[4];
      rsp_in.pix5       = under ? cell_ff.fg : cell_ff.bg;
      rsp_in.last_line  = (line_ff == 3'(CELL_H - 1));
      rsp_valid_in      = active_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (active_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.active = active_ff;
   assign status.last   = last;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

### tb/text_cell_glyph_renderer_unit_test.sv
`timescale 1ns / 1ps
// text_cell_glyph_renderer_unit_test: self-checking bench for the text cell glyph renderer
// drives cells, font and palette writes and the offset register; predicts every row beat
// depends on tcg_pkg and text_cell_glyph_renderer_unit

module text_cell_glyph_renderer_unit_test;
   import tcg_pkg::*;

   localparam int         SETTLE_CYCLES   = 6;
   localparam int         STALL_LIMIT     = 1000;
   localparam logic [2:0] ADDR_TOP_OFFSET = 3'd0;
   localparam logic [1:0] MODE_UNUSED     = 2'd3;
   localparam logic [7:0] OFFSET_RESET    = 8'd3;

   // reset colors, entry 0 is the rightmost
   localparam logic [15:0][15:0] RESET_PALETTE = {
      16'hFFFF, 16'hFFE0, 16'hFABF, 16'hFAAA, 16'h57FF, 16'h57EA, 16'h52BF, 16'h52AA,
      16'hAD55, 16'hA520, 16'hA815, 16'hA800, 16'h0555, 16'h0540, 16'h0015, 16'h0000};

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // shadow copy of the block state
   logic [7:0]  font_shadow [FONT_BYTES];
   bit          font_loaded [FONT_BYTES];
   bit          glyph_ready [GLYPH_COUNT];
   logic [7:0]  ready_glyphs [$];
   logic [15:0] palette_shadow [PAL_DEPTH];
   logic [7:0]  top_offset_shadow;

   rsp_type     pending_rows [$];
   rsp_type     row_want;
   bit          idle_enabled;
   int          mismatches;
   int          cells_rendered;
   int          rows_checked;
   int          font_writes;
   int          palette_writes;
   int          stall_count;

   text_cell_glyph_renderer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // eight row beats of one cell inside the grid
   function automatic void predict_cell_rows(input req_type cmd);
      logic [15:0]      fg;
      logic [15:0]      bg;
      logic [4:0][15:0] px;
      logic [31:0]      y;
      logic             under;
      rsp_type          row;
      fg = palette_shadow[cmd.fg_index];
      bg = palette_shadow[cmd.bg_index];
      for (int line = 0; line < CELL_H; line++) begin
         under = cmd.cursor_on && (line >= CELL_H - CURSOR_LINES);
         for (int c = 0; c < FONT_COLS; c++) begin
            if (under)
               px[c] = fg;
            else if (int'(cmd.char_code) < GLYPH_COUNT &&
                     font_shadow[int'(cmd.char_code) * FONT_COLS + c][line])
               px[c] = fg;
            else
               px[c] = bg;
         end
         y = 32'(top_offset_shadow) + 32'(cmd.text_row) * CELL_H + line;
         row.pixel_x    = 9'(int'(cmd.cell_col) * 6);
         row.pixel_y    = y[8:0];
         row.glyph_line = 3'(line);
         row.pix0       = px[0];
         row.pix1       = px[1];
         row.pix2       = px[2];
         row.pix3       = px[3];
         row.pix4       = px[4];
         row.pix5       = under ? fg : bg;
         row.last_line  = (line == CELL_H - 1);
         pending_rows.push_back(row);
      end
      cells_rendered++;
   endfunction

   // update the shadow state for one accepted command
   function automatic void apply_command(input req_type cmd);
      int  code;
      bit  full;
      unique case (cmd.mode)
         MODE_RENDER: begin
            if (cmd.cell_col < GRID_COLUMNS && cmd.text_row < GRID_ROWS)
               predict_cell_rows(cmd);
         end
         MODE_FONT_WR: begin
            if (cmd.table_index < FONT_BYTES) begin
               font_shadow[cmd.table_index] = cmd.table_value[7:0];
               font_loaded[cmd.table_index] = 1'b1;
               font_writes++;
               code = int'(cmd.table_index) / FONT_COLS;
               full = 1'b1;
               for (int c = 0; c < FONT_COLS; c++)
                  full = full && font_loaded[code * FONT_COLS + c];
               if (full && !glyph_ready[code]) begin
                  glyph_ready[code] = 1'b1;
                  ready_glyphs.push_back(8'(code));
               end
            end
         end
         MODE_PAL_WR: begin
            if (cmd.table_index < PAL_DEPTH) begin
               palette_shadow[cmd.table_index] = cmd.table_value;
               palette_writes++;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // row beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rows.size() == 0) begin
            mismatches++;
            $display("%0t: row beat with nothing expected, expected none, actual %p",
                     $time, rsp_data);
         end else begin
            row_want = pending_rows.pop_front();
            check_field("pixel_x", 16'(row_want.pixel_x), 16'(rsp_data.pixel_x));
            check_field("pixel_y", 16'(row_want.pixel_y), 16'(rsp_data.pixel_y));
            check_field("glyph_line", 16'(row_want.glyph_line), 16'(rsp_data.glyph_line));
            check_field("pix0", row_want.pix0, rsp_data.pix0);
            check_field("pix1", row_want.pix1, rsp_data.pix1);
            check_field("pix2", row_want.pix2, rsp_data.pix2);
            check_field("pix3", row_want.pix3, rsp_data.pix3);
            check_field("pix4", row_want.pix4, rsp_data.pix4);
            check_field("pix5", row_want.pix5, rsp_data.pix5);
            check_field("last_line", 16'(row_want.last_line), 16'(rsp_data.last_line));
            rows_checked++;
         end
      end
   end

   // watchdog on cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_count <= 0;
      end else if (stall_count == STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d rows still expected", $time,
                  STALL_LIMIT, pending_rows.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // one command beat; returns at the falling edge after acceptance with start still high
   task automatic send_command(input req_type cmd);
      start    <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (busy !== 1'b0);
      apply_command(cmd);
      @(negedge clock);
   endtask

   task automatic maybe_idle();
      if (idle_enabled && $urandom_range(99) < 22) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // hold off until every expected row is back and the block has gone quiet
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      start   <= 1'b0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == ADDR_TOP_OFFSET)
         top_offset_shadow = data[7:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read_check(input logic [2:0] addr);
      start   <= 1'b0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== {24'h0, top_offset_shadow}) begin
         mismatches++;
         $display("%0t: top_offset read mismatch, expected %h, actual %h", $time,
                  {24'h0, top_offset_shadow}, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_glyph();
      return ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
   endfunction

   // all fields but the mode random, char code limited to fully loaded glyphs
   function automatic req_type random_command(input logic [1:0] mode);
      req_type cmd;
      cmd.mode        = mode;
      cmd.char_code   = pick_glyph();
      cmd.fg_index    = 4'($urandom);
      cmd.bg_index    = 4'($urandom);
      cmd.cursor_on   = 1'($urandom);
      cmd.cell_col    = 6'($urandom_range(GRID_COLUMNS - 1));
      cmd.text_row    = 5'($urandom_range(GRID_ROWS - 1));
      cmd.table_index = 11'($urandom);
      cmd.table_value = 16'($urandom);
      return cmd;
   endfunction

   function automatic req_type cell_command(input logic [7:0] code, input int col,
                                            input int row, input logic [3:0] fg,
                                            input logic [3:0] bg, input logic cursor);
      req_type cmd;
      cmd           = random_command(MODE_RENDER);
      cmd.char_code = code;
      cmd.cell_col  = 6'(col);
      cmd.text_row  = 5'(row);
      cmd.fg_index  = fg;
      cmd.bg_index  = bg;
      cmd.cursor_on = cursor;
      return cmd;
   endfunction

   function automatic req_type table_command(input logic [1:0] mode, input int idx,
                                             input logic [15:0] value);
      req_type cmd;
      cmd             = random_command(mode);
      cmd.table_index = 11'(idx);
      cmd.table_value = value;
      return cmd;
   endfunction

   // five font columns of one glyph, column 0 in the low byte
   task automatic load_glyph(input logic [7:0] code, input logic [39:0] cols);
      req_type cmd;
      for (int c = 0; c < FONT_COLS; c++) begin
         cmd.mode        = MODE_FONT_WR;
         cmd.char_code   = code;
         cmd.fg_index    = 4'($urandom);
         cmd.bg_index    = 4'($urandom);
         cmd.cursor_on   = 1'($urandom);
         cmd.cell_col    = 6'($urandom);
         cmd.text_row    = 5'($urandom);
         cmd.table_index = 11'(int'(code) * FONT_COLS + c);
         cmd.table_value = {8'($urandom), cols[c*8 +: 8]};
         send_command(cmd);
      end
   endtask

   task automatic test_register_access();
      csr_read_check(ADDR_TOP_OFFSET);
      csr_write(ADDR_TOP_OFFSET, 32'h0000_00A5);
      csr_read_check(ADDR_TOP_OFFSET);
      csr_write(ADDR_TOP_OFFSET, 32'(OFFSET_RESET));
   endtask

   task automatic test_font_load();
      idle_enabled = 1'b0;
      load_glyph(8'h00, 40'h00_00_00_00_00);
      load_glyph(8'hFF, 40'hFF_FF_FF_FF_FF);
      load_glyph(8'h5A, 40'hFF_18_24_42_81);
      wait_drained();
   endtask

   task automatic test_cell_rendering();
      idle_enabled = 1'b1;
      // grid corners, color extremes, cursor on and off
      send_command(cell_command(8'h5A, 0, 0, 4'd15, 4'd0, 1'b0));
      send_command(cell_command(8'h5A, GRID_COLUMNS - 1, GRID_ROWS - 1, 4'd0, 4'd15, 1'b1));
      send_command(cell_command(8'hFF, 20, 7, 4'd14, 4'd1, 1'b1));
      send_command(cell_command(8'h00, 1, 1, 4'd4, 4'd2, 1'b1));
      // cells just and far outside the grid
      send_command(cell_command(8'h5A, GRID_COLUMNS, 0, 4'd15, 4'd0, 1'b0));
      send_command(cell_command(8'h5A, 0, GRID_ROWS, 4'd15, 4'd0, 1'b1));
      send_command(cell_command(8'hFF, 63, 31, 4'd10, 4'd5, 1'b1));
      wait_drained();
   endtask

   task automatic test_table_writes();
      send_command(table_command(MODE_PAL_WR, PAL_DEPTH - 1, 16'h0000));
      send_command(table_command(MODE_PAL_WR, 0, 16'hFFFF));
      send_command(table_command(MODE_PAL_WR, PAL_DEPTH, 16'h1234));
      send_command(table_command(MODE_PAL_WR, 2047, 16'hBEEF));
      send_command(table_command(MODE_FONT_WR, FONT_BYTES - 1, 16'hA50F));
      send_command(table_command(MODE_FONT_WR, FONT_BYTES, 16'h00F0));
      send_command(table_command(MODE_FONT_WR, 2047, 16'hFF3C));
      send_command(table_command(MODE_UNUSED, 5, 16'h5555));
      // render with the rewritten colors and the rewritten last font byte
      send_command(cell_command(8'hFF, 5, 3, 4'd0, 4'd15, 1'b0));
      send_command(cell_command(8'h5A, 6, 4, 4'd15, 4'd0, 1'b1));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input logic [7:0] offset);
      req_type cmd;
      int      pick;
      wait_drained();
      csr_write(ADDR_TOP_OFFSET, 32'(offset));
      csr_read_check(ADDR_TOP_OFFSET);
      for (int i = 0; i < count; i++) begin
         // a quiet stretch with back-to-back commands, and one full drain midway
         idle_enabled = !(i >= count / 4 && i < count / 2);
         if (i == count / 2)
            wait_drained();
         pick = $urandom_range(99);
         if (pick < 55) begin
            cmd = random_command(MODE_RENDER);
         end else if (pick < 65) begin
            cmd = random_command(MODE_RENDER);
            if ($urandom_range(1))
               cmd.cell_col = 6'($urandom_range(63, GRID_COLUMNS));
            else
               cmd.text_row = 5'($urandom_range(31, GRID_ROWS));
            cmd.cell_col = $urandom_range(3) == 0 ? 6'($urandom) : cmd.cell_col;
         end else if (pick < 82) begin
            cmd = random_command(MODE_FONT_WR);
            if ($urandom_range(9) == 0)
               cmd.table_index = 11'($urandom_range(2047, FONT_BYTES));
            else if ($urandom_range(9) < 6)
               cmd.table_index = 11'(int'(pick_glyph()) * FONT_COLS + $urandom_range(4));
            else
               cmd.table_index = 11'($urandom_range(FONT_BYTES - 1));
         end else if (pick < 95) begin
            cmd = random_command(MODE_PAL_WR);
            if ($urandom_range(7) == 0)
               cmd.table_index = 11'($urandom_range(2047, PAL_DEPTH));
            else
               cmd.table_index = 11'($urandom_range(PAL_DEPTH - 1));
         end else begin
            cmd = random_command(MODE_UNUSED);
         end
         send_command(cmd);
         maybe_idle();
      end
      wait_drained();
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_data          = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      idle_enabled      = 1'b0;
      mismatches        = 0;
      cells_rendered    = 0;
      rows_checked      = 0;
      font_writes       = 0;
      palette_writes    = 0;
      stall_count       = 0;
      top_offset_shadow = OFFSET_RESET;
      for (int i = 0; i < FONT_BYTES; i++) begin
         font_shadow[i] = 8'h00;
         font_loaded[i] = 1'b0;
      end
      for (int i = 0; i < GLYPH_COUNT; i++)
         glyph_ready[i] = 1'b0;
      for (int i = 0; i < PAL_DEPTH; i++)
         palette_shadow[i] = RESET_PALETTE[i];

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_access();
      test_font_load();
      test_cell_rendering();
      test_table_writes();
      test_random_traffic(65, 8'd0);
      test_random_traffic(65, 8'd255);
      test_random_traffic(65, 8'($urandom));
      wait_drained();

      $display("covered %0d cells as %0d checked row beats, %0d font and %0d palette writes,",
               cells_rendered, rows_checked, font_writes, palette_writes);
      $display("cells off the grid, ignored writes and offsets 3, 0, 255 and a random one");
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
src/tcg_pkg.sv
src/tcg_font_mem.sv
src/tcg_palette.sv
src/tcg_line_gen.sv
src/text_cell_glyph_renderer_unit.sv
tb/text_cell_glyph_renderer_unit_test.sv
